// ----- sv/wrcs_pkg.sv -----
// ----------------------------------------------------------------------------
// wrcs_pkg
// Shared types and widths for the weighted residual chi-squared core.
// ----------------------------------------------------------------------------
package wrcs_pkg;

    localparam int ObsW     = 16;
    localparam int WgtW     = 16;
    localparam int TgtW     = 16;
    localparam int ProdW    = ObsW + WgtW + 1;   // signed x unsigned
    localparam int AccW     = 48;                // Q23.24 row sum
    localparam int ResW     = 25;                // Q16.8 residual
    localparam int SqW      = 49;                // Q32.16 square
    localparam int TotW     = 62;                // Q46.16 total
    localparam int HalfW    = 61;
    localparam int STdataW  = 48;
    localparam int MTdataW  = 112;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ACC  = 5'b00010,
        S_RES  = 5'b00100,
        S_SQR  = 5'b01000,
        S_TOT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic load_in;
        logic acc_en;
        logic res_en;
        logic sqr_en;
        logic tot_en;
    } cmd_t;

    typedef struct packed {
        logic row_end;
        logic out_free;
    } status_t;

endpackage

// ----- sv/wrcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// wrcs_ctrl
// Sequencer: one item at a time, row-end items walk the residual steps.
// ----------------------------------------------------------------------------
module wrcs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  wrcs_pkg::status_t status,
    output wrcs_pkg::cmd_t    cmd
);
    import wrcs_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                state_next = status.row_end ? S_RES : S_IDLE;
            end
            S_RES:
            begin
                state_next = S_SQR;
            end
            S_SQR:
            begin
                state_next = S_TOT;
            end
            S_TOT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.load_in = (state_reg == S_IDLE) && in_valid;
    assign cmd.acc_en  = (state_reg == S_ACC);
    assign cmd.res_en  = (state_reg == S_RES);
    assign cmd.sqr_en  = (state_reg == S_SQR);
    assign cmd.tot_en  = (state_reg == S_TOT) && status.out_free;

endmodule

// ----- sv/wrcs_datapath.sv -----
// ----------------------------------------------------------------------------
// wrcs_datapath
// Multiply, row accumulate, residual, square, total and output register.
// ----------------------------------------------------------------------------
module wrcs_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  wrcs_pkg::cmd_t                 cmd,
    output wrcs_pkg::status_t              status,
    input  logic [wrcs_pkg::STdataW-1:0]   in_data,
    input  logic                           in_row_end,
    input  logic                           in_last_row,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [wrcs_pkg::MTdataW-1:0]   out_data,
    output logic                           out_last
);
    import wrcs_pkg::*;

    logic signed [ObsW-1:0]  obs;
    logic        [WgtW-1:0]  wgt;
    logic signed [ProdW-1:0] prod_next;

    logic signed [ProdW-1:0] prod_reg;
    logic signed [TgtW-1:0]  tgt_reg;
    logic                    row_end_reg;
    logic                    last_row_reg;

    logic [AccW-1:0]  acc_reg;
    logic [AccW-1:0]  rowsum_reg;
    logic [AccW:0]    acc_sum;
    logic [AccW-1:0]  acc_sat;

    logic [AccW:0]    diff;
    logic [AccW-16:0] shifted;
    logic [ResW-1:0]  res_sat;
    logic [ResW-1:0]  mag_next;
    logic [ResW-1:0]  mag_reg;

    logic [2*ResW-1:0] sq_full;
    logic [SqW-1:0]    sq_reg;

    logic [TotW:0]     tot_sum;
    logic [TotW-1:0]   tot_sat;
    logic [TotW-1:0]   total_reg;

    logic [SqW-1:0]    out_sq_reg;
    logic [HalfW-1:0]  out_half_reg;
    logic              out_last_reg;
    logic              out_valid_reg;

    assign obs       = in_data[ObsW-1:0];
    assign wgt       = in_data[ObsW+WgtW-1:ObsW];
    assign prod_next = obs * $signed({1'b0, wgt});

    // saturate the row sum to the 48-bit signed range
    assign acc_sum = {acc_reg[AccW-1], acc_reg}
                   + {{(AccW+1-ProdW){prod_reg[ProdW-1]}}, prod_reg};
    always_comb
    begin
        if (acc_sum[AccW] != acc_sum[AccW-1])
        begin
            acc_sat = acc_sum[AccW] ? {1'b1, {(AccW-1){1'b0}}}
                                    : {1'b0, {(AccW-1){1'b1}}};
        end
        else
        begin
            acc_sat = acc_sum[AccW-1:0];
        end
    end

    // residual in Q.24, floor to Q16.8, saturate to 25 bits
    assign diff    = {rowsum_reg[AccW-1], rowsum_reg}
                   - {{(AccW+1-TgtW-16){tgt_reg[TgtW-1]}}, tgt_reg, 16'b0};
    assign shifted = diff[AccW:16];
    always_comb
    begin
        if (shifted[AccW-16:ResW-1] == '0 || shifted[AccW-16:ResW-1] == '1)
        begin
            res_sat = shifted[ResW-1:0];
        end
        else if (shifted[AccW-16])
        begin
            res_sat = {1'b1, {(ResW-1){1'b0}}};
        end
        else
        begin
            res_sat = {1'b0, {(ResW-1){1'b1}}};
        end
    end
    assign mag_next = res_sat[ResW-1] ? (~res_sat + 1'b1) : res_sat;

    assign sq_full = mag_reg * mag_reg;

    // saturating total
    assign tot_sum = {1'b0, total_reg} + {{(TotW+1-SqW){1'b0}}, sq_reg};
    assign tot_sat = tot_sum[TotW] ? {TotW{1'b1}} : tot_sum[TotW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            prod_reg     <= prod_next;
            tgt_reg      <= in_data[ObsW+WgtW+TgtW-1:ObsW+WgtW];
            row_end_reg  <= in_row_end;
            last_row_reg <= in_last_row;
        end
        if (cmd.acc_en)
        begin
            rowsum_reg <= acc_sat;
        end
        if (cmd.res_en)
        begin
            mag_reg <= mag_next;
        end
        if (cmd.sqr_en)
        begin
            sq_reg <= sq_full[SqW-1:0];
        end
        if (cmd.tot_en)
        begin
            out_sq_reg   <= sq_reg;
            out_half_reg <= last_row_reg ? tot_sat[TotW-1:1] : '0;
            out_last_reg <= last_row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc_en)
            begin
                acc_reg <= row_end_reg ? '0 : acc_sat;
            end
            if (cmd.tot_en)
            begin
                total_reg     <= last_row_reg ? '0 : tot_sat;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.row_end  = row_end_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = {{(MTdataW-SqW-HalfW){1'b0}}, out_half_reg, out_sq_reg};
    assign out_last  = out_last_reg;

endmodule

// ----- sv/weighted_residual_chi_squared_core.sv -----
// ----------------------------------------------------------------------------
// weighted_residual_chi_squared_core
// Streaming half residual sum of squares over a weighted matrix.
// ----------------------------------------------------------------------------
// Steps: a row-end beat walks accumulate, residual, square and total into
//   the output register, the total step holding while the output stalls.
// Flow: other beats take only the accumulate step. No new beat is taken
//   until the last one has finished its steps, set by the single-item
//   sequencer and the residual/square steps that share it.
// Reset: rst_n clears the row accumulator, the total and the output valid.
// ----------------------------------------------------------------------------
module weighted_residual_chi_squared_core (
    input  logic                              clk,
    input  logic                              rst_n,
    // input beats: one matrix entry each
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [wrcs_pkg::STdataW-1:0]      s_axis_tdata,  // obs_value, weight, target
    input  logic                              s_axis_tlast,  // row_end
    input  logic                              s_axis_tuser,  // last_row
    // result beats: one per finished row
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [wrcs_pkg::MTdataW-1:0]      m_axis_tdata,  // row_sq_residual, half_chi_sq, pad
    output logic                              m_axis_tlast   // final_res
);
    import wrcs_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer: takes a beat, runs the accumulate step, and for a row end
    // walks residual, square and total before taking the next beat.
    wrcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: product is registered at the accept edge, the row sum
    // saturates at 48 bits, the residual is floored to Q16.8 and clamped,
    // then squared and added into the 62-bit saturating total. The output
    // register lets the next row's beats enter while a result waits.
    wrcs_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_data     (s_axis_tdata),
        .in_row_end  (s_axis_tlast),
        .in_last_row (s_axis_tuser),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

endmodule
